// ===== src/smp_pkg.sv =====
package smp_pkg;

  localparam int unsigned PATTERN_MAX_DEF   = 8;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned PATTERN_LIMIT     = 8;   // the effective pattern length is at most eight bytes
  localparam int unsigned LEN_CALC_W        = 6;   // covers cell indexes up to 63
  localparam int unsigned FIFO_DEPTH        = 4;

  localparam logic [7:0] LEAD_BYTE = 8'hC3;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  localparam logic REG_PATTERN_BYTES  = 1'b0;
  localparam logic REG_PATTERN_LENGTH = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [15:0] occurrences;
    logic        last;
  } result_t;

  // per-cell compare results for the byte just shifted in
  typedef struct packed {
    logic match;
    logic lead;
  } cell_flags_t;

endpackage

// ===== src/substring_match_positions.sv =====
// Channel   Dir   Handshake              Payload
// text      in    text_valid/text_ready  text_item_t: text_byte, end_of_text
// res       out   res_valid/res_ready    result_t: kind, start_pos, end_pos, occurrences, last
// cfg       in    cfg_valid/cfg_ready    cfg_index (0 pattern_bytes, 1 pattern_length), cfg_data
//
// One text byte per cycle while text_ready is high. A byte shifts through the cell row on acceptance; its
// result items enter the output queue from stage A once the queue has room, and then appear at the output.
// A byte that ends a text on a match makes two items; the output port drains one
// per cycle while res_ready is high, so such bytes can fill the queue and hold text_ready low.
// text_ready drops only when the four-entry output queue has fewer than two free slots.
// Synchronous reset clears the window, counters, queue and pattern_bytes, and sets pattern_length to 1.
module substring_match_positions
  import smp_pkg::*;
#(
  parameter int unsigned PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  text_item_t  text,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned P     = POSITION_BITS;
  localparam int unsigned LIM   = (PATTERN_MAX < PATTERN_LIMIT) ? PATTERN_MAX : PATTERN_LIMIT;
  localparam int unsigned RC_W  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [P-1:0] CNT_MAX = '1;

  // configuration
  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [3:0]  len_eff;
  logic [LEN_CALC_W-1:0] len6;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == 4'd0) begin
      len_eff = 4'd1;
    end else if (pattern_length > 4'(LIM)) begin
      len_eff = 4'(LIM);
    end else begin
      len_eff = pattern_length;
    end
  end

  assign len6 = LEN_CALC_W'(len_eff);

  // input side: counters and stage A
  logic         text_acc;
  logic         adv_a;
  logic         valid_a;
  logic [P-1:0] bytes_seen;
  logic [P-1:0] lead_seen;
  logic [P-1:0] bytes_seen_next;
  logic [P-1:0] lead_seen_next;
  logic [P-1:0] bs_a;
  logic [P-1:0] lead_a;
  logic         eot_a;
  logic [CNT_W-1:0] fifo_count;

  assign adv_a      = valid_a && (fifo_count <= CNT_W'(FIFO_DEPTH - 2));
  assign text_ready = !valid_a || adv_a;
  assign text_acc   = text_valid && text_ready;

  assign bytes_seen_next = (bytes_seen < CNT_MAX) ? bytes_seen + P'(1) : bytes_seen;
  assign lead_seen_next  = ((text.text_byte == LEAD_BYTE) && (lead_seen < CNT_MAX)) ?
                           lead_seen + P'(1) : lead_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a    <= 1'b0;
      bytes_seen <= '0;
      lead_seen  <= '0;
    end else begin
      if (text_acc) begin
        valid_a    <= 1'b1;
        bytes_seen <= text.end_of_text ? '0 : bytes_seen_next;
        lead_seen  <= text.end_of_text ? '0 : lead_seen_next;
      end else if (adv_a) begin
        valid_a <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      bs_a   <= bytes_seen_next;
      lead_a <= lead_seen_next;
      eot_a  <= text.end_of_text;
    end
  end

  // cell row: cell i holds window byte i, newest in cell 0
  logic [7:0]  win   [PATTERN_MAX];
  cell_flags_t flags [PATTERN_MAX];

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [7:0]            din;
    logic [LEN_CALC_W-1:0] sel;

    // cell i lines up with pattern byte len-1-i
    assign sel = len6 - LEN_CALC_W'(1) - LEN_CALC_W'(i);

    if (i == 0) begin : g_head
      assign din = text.text_byte;
    end else begin : g_body
      assign din = win[i-1];
    end

    smp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (text_acc),
      .clear    (text.end_of_text),
      .din      (din),
      .pat      (pattern_bytes[{sel[2:0], 3'b000} +: 8]),
      .match_en (LEN_CALC_W'(i) < len6),
      .lead_en  ((LEN_CALC_W'(i) + LEN_CALC_W'(1)) < len6),
      .q        (win[i]),
      .flags    (flags[i])
    );
  end

  // stage B: position arithmetic and result build
  logic              all_match;
  logic [RC_W-1:0]   recent;
  logic              hit;
  logic [P-1:0]      len_p;
  logic [P-1:0]      first;
  logic [P-1:0]      lead_at_start;
  logic [P-1:0]      s_pos;
  logic [P:0]        e_wide;
  logic [P-1:0]      e_pos;
  logic [P-1:0]      match_total;
  logic [P-1:0]      total_inc;
  result_t           match_res;
  result_t           total_res;
  result_t           data0;
  logic              push0;
  logic              push1;

  always_comb begin
    all_match = 1'b1;
    recent    = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      all_match = all_match && flags[k].match;
      recent    = recent + RC_W'(flags[k].lead);
    end
  end

  assign len_p = P'(len_eff);
  assign hit   = all_match && (bs_a >= len_p);
  assign first = bs_a - len_p + P'(1);

  assign lead_at_start = (lead_a > P'(recent)) ? lead_a - P'(recent) : '0;
  assign s_pos  = (first > lead_at_start) ? first - lead_at_start : '0;
  assign e_wide = {1'b0, s_pos} + (P+1)'(len_p) - (P+1)'(1);
  assign e_pos  = e_wide[P] ? CNT_MAX : e_wide[P-1:0];

  assign total_inc = (hit && (match_total < CNT_MAX)) ? match_total + P'(1) : match_total;

  always_comb begin
    match_res.kind        = KIND_MATCH;
    match_res.start_pos   = 16'(s_pos);
    match_res.end_pos     = 16'(e_pos);
    match_res.occurrences = 16'(total_inc);
    match_res.last        = !eot_a;

    total_res.kind        = KIND_TOTAL;
    total_res.start_pos   = '0;
    total_res.end_pos     = '0;
    total_res.occurrences = 16'(total_inc);
    total_res.last        = 1'b1;
  end

  assign push0 = adv_a && (hit || eot_a);
  assign push1 = adv_a && hit && eot_a;
  assign data0 = hit ? match_res : total_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_total <= '0;
    end else if (adv_a) begin
      match_total <= eot_a ? '0 : total_inc;
    end
  end

  smp_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .data0     (data0),
    .data1     (total_res),
    .count     (fifo_count),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_total_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_TOTAL) |-> res.last)
    else $error("total item without last");

  a_eot_clear: assert property (@(posedge clk) disable iff (rst)
    (text_acc && text.end_of_text) |=> (bytes_seen == '0 && lead_seen == '0))
    else $error("counters not cleared after end of text");

  a_total_clear: assert property (@(posedge clk) disable iff (rst)
    (adv_a && eot_a) |=> (match_total == '0))
    else $error("match total not cleared after end of text");

endmodule

// ===== src/smp_cell.sv =====
module smp_cell
  import smp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        shift,
  input  logic        clear,
  input  logic [7:0]  din,
  input  logic [7:0]  pat,
  input  logic        match_en,
  input  logic        lead_en,
  output logic [7:0]  q,
  output cell_flags_t flags
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= clear ? 8'h00 : din;
    end
  end

  // flags describe the byte shifted in, whether or not the window is cleared
  always_ff @(posedge clk) begin
    if (shift) begin
      flags.match <= !match_en || (din == pat);
      flags.lead  <= lead_en && (din == LEAD_BYTE);
    end
  end

endmodule

// ===== src/smp_result_fifo.sv =====
module smp_result_fifo
  import smp_pkg::*;
#(
  parameter int unsigned PTR_W = $clog2(FIFO_DEPTH),
  parameter int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push0,
  input  logic             push1,
  input  result_t          data0,
  input  result_t          data1,
  output logic [CNT_W-1:0] count,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [1:0]       push_n;
  logic             pop;

  // push1 is only raised together with push0
  assign push_n    = {1'b0, push0} + {1'b0, push1};
  assign pop       = (count != '0) && res_ready;
  assign res_valid = (count != '0);
  assign res       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= data0;
    end
    if (push1) begin
      mem[wr_ptr + PTR_W'(1)] <= data1;
    end
  end

endmodule
